@@ rtl/srt_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and codes of the segment reassembly tracker.
// No dependencies.
package srt_pkg;

    localparam int SEQ_W   = 10;
    localparam int OFF_W   = 16;
    localparam int LEN_W   = 12;
    localparam int ST_W    = 4;
    localparam int BYTES_W = 17;
    localparam int TMR_W   = 16;

    localparam logic [BYTES_W-1:0] BYTES_MAX   = '1;
    localparam logic [TMR_W-1:0]   TIMEOUT_RST = 16'd5000;

    localparam logic REG_TIMEOUT = 1'b0;

    localparam logic [1:0] KIND_COMPLETE = 2'd0;
    localparam logic [1:0] KIND_FIRST    = 2'd1;
    localparam logic [1:0] KIND_MIDDLE   = 2'd2;
    localparam logic [1:0] KIND_LAST     = 2'd3;

    localparam logic [ST_W-1:0] ST_DELIVERED   = 4'd0;
    localparam logic [ST_W-1:0] ST_EMPTY       = 4'd1;
    localparam logic [ST_W-1:0] ST_TOO_SHORT   = 4'd2;
    localparam logic [ST_W-1:0] ST_NO_SESSION  = 4'd3;
    localparam logic [ST_W-1:0] ST_OVERFLOW    = 4'd4;
    localparam logic [ST_W-1:0] ST_STORED      = 4'd5;
    localparam logic [ST_W-1:0] ST_REASSEMBLED = 4'd6;
    localparam logic [ST_W-1:0] ST_MISMATCH    = 4'd7;
    localparam logic [ST_W-1:0] ST_TICK        = 4'd8;

    typedef struct packed {
        logic [BYTES_W-1:0] bytes;
        logic [TMR_W-1:0]   timer;
    } t_ctx;

    typedef struct packed {
        logic hit;
        logic alloc;
    } t_find;

endpackage

@@ rtl/srt_if.sv @@
`timescale 1ns / 1ps
// Request and response channel interfaces of the segment reassembly tracker.
// No dependencies.
interface srt_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [1:0]  seg_kind;
    logic [9:0]  seq_num;
    logic [15:0] byte_offset;
    logic [11:0] pdu_len;

    modport source (output valid, req_type, seg_kind, seq_num, byte_offset, pdu_len,
                    input ready);
    modport sink   (input valid, req_type, seg_kind, seq_num, byte_offset, pdu_len,
                    output ready);
endinterface

interface srt_rsp_if;
    logic        valid;
    logic        ready;
    logic [3:0]  status;
    logic [1:0]  session_index;
    logic [15:0] deliver_len;
    logic [9:0]  deliver_seq;
    logic [3:0]  expired_mask;

    modport source (output valid, status, session_index, deliver_len, deliver_seq,
                    expired_mask, input ready);
    modport sink   (input valid, status, session_index, deliver_len, deliver_seq,
                    expired_mask, output ready);
endinterface

@@ rtl/srt_find.sv @@
`timescale 1ns / 1ps
// Session lookup: lowest active slot matching the sequence number, else lowest free slot.
// Depends on srt_pkg.
module srt_find import srt_pkg::*; #(
    parameter int SESSIONS = 4
) (
    input  logic [SESSIONS-1:0]            i_active,
    input  logic [SESSIONS-1:0][SEQ_W-1:0] i_sseq,
    input  logic [SEQ_W-1:0]               i_seq,
    input  logic                           i_first,
    output t_find                          o_find,
    output logic [((SESSIONS > 1) ? $clog2(SESSIONS) : 1)-1:0] o_slot
);
    localparam int IW = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;

    logic          m_hit;
    logic          f_hit;
    logic [IW-1:0] m_slot;
    logic [IW-1:0] f_slot;

    always_comb begin
        m_hit  = 1'b0;
        f_hit  = 1'b0;
        m_slot = '0;
        f_slot = '0;
        for (int i = SESSIONS - 1; i >= 0; i--) begin
            if (i_active[i] && (i_sseq[i] == i_seq)) begin
                m_hit  = 1'b1;
                m_slot = IW'(i);
            end
            if (!i_active[i]) begin
                f_hit  = 1'b1;
                f_slot = IW'(i);
            end
        end
        o_find.hit   = m_hit || (i_first && f_hit);
        o_find.alloc = !m_hit && i_first && f_hit;
        o_slot       = m_hit ? m_slot : f_slot;
    end

endmodule

@@ rtl/segment_reassembly_tracker_core.sv @@
`timescale 1ns / 1ps
// Segment reassembly session tracker, top level.
// Depends on srt_pkg, srt_if and srt_find.
//
//  channel  | dir | handshake        | contents
//  ---------+-----+------------------+------------------------------------------
//  i_req    | in  | valid/ready      | PDU descriptor or timer tick
//  o_rsp    | out | valid/ready      | status, slot, length, sequence, expiry mask
//  APB      | in  | psel/penable     | reassembly_timeout_ticks at address 0
//
// A PDU descriptor is handled as session lookup and context read, then
// read-modify-write of the context memory. A tick sweeps the context memory,
// one entry per cycle.
// Reset is synchronous, active low, and needs no clearing pass.
// The result register decouples the output; processing holds in its last
// cycle while an earlier result is still unread.
module segment_reassembly_tracker_core import srt_pkg::*; #(
    parameter int SESSIONS        = 4,
    parameter int BUF_BYTES       = 4096,
    parameter int BASIC_HDR_BYTES = 2,
    parameter int SEG_HDR_BYTES   = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    srt_req_if.sink     i_req,
    srt_rsp_if.source   o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int IW = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
    localparam logic [LEN_W-1:0]   HDR_B    = LEN_W'(BASIC_HDR_BYTES);
    localparam logic [LEN_W-1:0]   HDR_S    = LEN_W'(SEG_HDR_BYTES);
    localparam logic [BYTES_W-1:0] BUF_LIM  = BYTES_W'(BUF_BYTES);
    localparam logic [IW-1:0]      LAST_IDX = IW'(SESSIONS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_TICK
    } t_state;

    function automatic logic [15:0] clip16(input logic [BYTES_W-1:0] v);
        return v[BYTES_W-1] ? 16'hFFFF : v[15:0];
    endfunction

    t_state                         r_state, n_state;
    logic [SESSIONS-1:0]            r_active, n_active;
    logic [SESSIONS-1:0][SEQ_W-1:0] r_sseq, n_sseq;
    logic [TMR_W-1:0]               r_timeout, n_timeout;
    logic [IW-1:0]                  r_idx, n_idx;
    logic [3:0]                     r_mask, n_mask;
    logic [1:0]                     r_kind, n_kind;
    logic [SEQ_W-1:0]               r_seq, n_seq;
    logic [OFF_W-1:0]               r_off, n_off;
    logic [LEN_W-1:0]               r_pay, n_pay;
    logic                           r_short, n_short;
    t_find                          r_find, n_find;
    logic [IW-1:0]                  r_slot, n_slot;
    logic                           r_out_valid, n_out_valid;
    logic [ST_W-1:0]                r_ost, n_ost;
    logic [1:0]                     r_oidx, n_oidx;
    logic [15:0]                    r_olen, n_olen;
    logic [SEQ_W-1:0]               r_oseq, n_oseq;
    logic [3:0]                     r_omask, n_omask;

    t_ctx          r_mem [SESSIONS];
    t_ctx          r_rd;
    logic          w_we;
    logic          w_re;
    logic [IW-1:0] w_wa;
    logic [IW-1:0] w_ra;
    t_ctx          w_wd;

    logic               w_accept;
    logic               w_go;
    logic               w_last;
    logic [LEN_W-1:0]   w_hdr;
    logic               w_short;
    t_find              w_find;
    logic [IW-1:0]      w_slot;
    logic [BYTES_W-1:0] w_old;
    logic [BYTES_W-1:0] w_end;
    logic [BYTES_W:0]   w_sum;
    logic [BYTES_W-1:0] w_sat;

    srt_find #(.SESSIONS(SESSIONS)) u_find (
        .i_active (r_active),
        .i_sseq   (r_sseq),
        .i_seq    (i_req.seq_num),
        .i_first  (i_req.seg_kind == KIND_FIRST),
        .o_find   (w_find),
        .o_slot   (w_slot)
    );

    assign i_req.ready         = (r_state == S_IDLE);
    assign w_accept            = i_req.valid && i_req.ready;
    assign w_go                = !r_out_valid || o_rsp.ready;
    assign w_last              = (r_idx == LAST_IDX);

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_ost;
    assign o_rsp.session_index = r_oidx;
    assign o_rsp.deliver_len   = r_olen;
    assign o_rsp.deliver_seq   = r_oseq;
    assign o_rsp.expired_mask  = r_omask;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TIMEOUT) ? {16'd0, r_timeout} : 32'd0;

    assign w_hdr   = ((i_req.seg_kind == KIND_COMPLETE) || (i_req.seg_kind == KIND_FIRST))
                     ? HDR_B : HDR_S;
    assign w_short = (i_req.pdu_len < w_hdr);

    assign w_old = r_find.alloc ? '0 : r_rd.bytes;
    assign w_end = BYTES_W'(r_off) + BYTES_W'(r_pay);
    assign w_sum = {1'b0, w_old} + (BYTES_W + 1)'(r_pay);
    assign w_sat = w_sum[BYTES_W] ? BYTES_MAX : w_sum[BYTES_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_active    = r_active;
        n_sseq      = r_sseq;
        n_timeout   = r_timeout;
        n_idx       = r_idx;
        n_mask      = r_mask;
        n_kind      = r_kind;
        n_seq       = r_seq;
        n_off       = r_off;
        n_pay       = r_pay;
        n_short     = r_short;
        n_find      = r_find;
        n_slot      = r_slot;
        n_out_valid = r_out_valid;
        n_ost       = r_ost;
        n_oidx      = r_oidx;
        n_olen      = r_olen;
        n_oseq      = r_oseq;
        n_omask     = r_omask;
        w_we        = 1'b0;
        w_re        = 1'b0;
        w_wa        = r_slot;
        w_ra        = r_slot;
        w_wd        = '0;

        if (psel && penable && pwrite && (paddr[2] == REG_TIMEOUT)) begin
            n_timeout = pwdata[TMR_W-1:0];
        end
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    w_re = 1'b1;
                    if (i_req.req_type) begin
                        n_idx   = '0;
                        n_mask  = '0;
                        w_ra    = '0;
                        n_state = S_TICK;
                    end else begin
                        n_kind  = i_req.seg_kind;
                        n_seq   = i_req.seq_num;
                        n_off   = (i_req.seg_kind == KIND_FIRST) ? '0 : i_req.byte_offset;
                        n_pay   = i_req.pdu_len - w_hdr;
                        n_short = w_short;
                        n_find  = w_find;
                        n_slot  = w_slot;
                        w_ra    = w_slot;
                        n_state = S_EXEC;
                    end
                end
            end
            S_EXEC: begin
                if (w_go) begin
                    n_out_valid = 1'b1;
                    n_oseq      = r_seq;
                    n_omask     = '0;
                    n_oidx      = '0;
                    n_olen      = '0;
                    n_state     = S_IDLE;
                    priority if (r_short) begin
                        n_ost = ST_TOO_SHORT;
                    end else if (r_kind == KIND_COMPLETE) begin
                        n_ost  = (r_pay != '0) ? ST_DELIVERED : ST_EMPTY;
                        n_olen = 16'(r_pay);
                    end else if (!r_find.hit) begin
                        n_ost = ST_NO_SESSION;
                    end else begin
                        n_oidx = 2'(r_slot);
                        n_olen = clip16(w_end);
                        w_we   = 1'b1;
                        if (r_find.alloc) begin
                            n_active[r_slot] = 1'b1;
                            n_sseq[r_slot]   = r_seq;
                        end
                        if (w_end > BUF_LIM) begin
                            n_ost            = ST_OVERFLOW;
                            n_active[r_slot] = 1'b0;
                        end else if (r_kind == KIND_LAST) begin
                            if (w_sat == w_end) begin
                                n_ost            = ST_REASSEMBLED;
                                n_active[r_slot] = 1'b0;
                            end else begin
                                n_ost      = ST_MISMATCH;
                                w_wd.bytes = w_sat;
                                w_wd.timer = r_rd.timer;
                            end
                        end else begin
                            n_ost      = ST_STORED;
                            n_olen     = clip16(w_sat);
                            w_wd.bytes = w_sat;
                            w_wd.timer = r_timeout;
                        end
                    end
                end
            end
            S_TICK: begin
                if (!w_last || w_go) begin
                    if (r_active[r_idx]) begin
                        w_we = 1'b1;
                        w_wa = r_idx;
                        if (r_rd.timer <= TMR_W'(1)) begin
                            n_active[r_idx] = 1'b0;
                            for (int j = 0; j < 4; j++) begin
                                if ((j < SESSIONS) && (r_idx == IW'(j))) begin
                                    n_mask[j] = 1'b1;
                                end
                            end
                        end else begin
                            w_wd.bytes = r_rd.bytes;
                            w_wd.timer = r_rd.timer - TMR_W'(1);
                        end
                    end
                    if (!w_last) begin
                        n_idx = r_idx + IW'(1);
                        w_ra  = r_idx + IW'(1);
                        w_re  = 1'b1;
                    end else begin
                        n_out_valid = 1'b1;
                        n_ost       = ST_TICK;
                        n_oidx      = '0;
                        n_olen      = '0;
                        n_oseq      = '0;
                        n_omask     = n_mask;
                        n_state     = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_active    <= '0;
            r_timeout   <= TIMEOUT_RST;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_active    <= n_active;
            r_timeout   <= n_timeout;
        end
        r_sseq  <= n_sseq;
        r_idx   <= n_idx;
        r_mask  <= n_mask;
        r_kind  <= n_kind;
        r_seq   <= n_seq;
        r_off   <= n_off;
        r_pay   <= n_pay;
        r_short <= n_short;
        r_find  <= n_find;
        r_slot  <= n_slot;
        r_ost   <= n_ost;
        r_oidx  <= n_oidx;
        r_olen  <= n_olen;
        r_oseq  <= n_oseq;
        r_omask <= n_omask;
    end

    // session context memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (w_re) begin
            r_rd <= r_mem[w_ra];
        end
    end

endmodule

@@ rtl/srt_chk.sv @@
`timescale 1ns / 1ps
// Port-level checks of the segment reassembly tracker and their bind.
// Depends on srt_pkg and segment_reassembly_tracker_core.
module srt_chk import srt_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [3:0]  i_rsp_status,
    input logic [1:0]  i_rsp_index,
    input logic [15:0] i_rsp_len,
    input logic [9:0]  i_rsp_seq,
    input logic [3:0]  i_rsp_mask
);
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("input taken on consecutive cycles");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_status)
            && $stable(i_rsp_len) && $stable(i_rsp_seq))
        else $error("stalled response changed");

    a_tick_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_status == ST_TICK) |->
            (i_rsp_index == 2'd0) && (i_rsp_len == 16'd0) && (i_rsp_seq == 10'd0))
        else $error("tick response carries segment fields");

    a_mask_only_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_status != ST_TICK) |-> (i_rsp_mask == 4'd0))
        else $error("expiry mask on a segment response");

    a_no_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && ((i_rsp_status == ST_TOO_SHORT) || (i_rsp_status == ST_NO_SESSION))
            |-> (i_rsp_index == 2'd0) && (i_rsp_len == 16'd0))
        else $error("dropped segment reports a slot or length");

endmodule

bind segment_reassembly_tracker_core srt_chk u_srt_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_status (o_rsp.status),
    .i_rsp_index  (o_rsp.session_index),
    .i_rsp_len    (o_rsp.deliver_len),
    .i_rsp_seq    (o_rsp.deliver_seq),
    .i_rsp_mask   (o_rsp.expired_mask)
);

@@ tb/tb_segment_reassembly_tracker_core.sv @@
`timescale 1ns / 1ps
// Self-checking bench for segment_reassembly_tracker_core: directed and random PDU traffic.
// Depends on srt_pkg, srt_if and the core; expected results come from an in-bench session table.
module tb_segment_reassembly_tracker_core;
    import srt_pkg::*;

    localparam int SESSIONS        = 4;
    localparam int BUF_BYTES       = 4096;
    localparam int BASIC_HDR_BYTES = 2;
    localparam int SEG_HDR_BYTES   = 4;

    localparam logic       REQ_PDU      = 1'b0;
    localparam logic       REQ_TICK     = 1'b1;
    localparam logic [2:0] TIMEOUT_ADDR = {REG_TIMEOUT, 2'b00};

    typedef struct packed {
        logic             req_type;
        logic [1:0]       kind;
        logic [SEQ_W-1:0] seq;
        logic [OFF_W-1:0] off;
        logic [LEN_W-1:0] plen;
    } t_pdu;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [1:0]       idx;
        logic [15:0]      len;
        logic [SEQ_W-1:0] seq;
        logic [3:0]       mask;
    } t_result;

    localparam int PDU_W = $bits(t_pdu);

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    srt_req_if req_ch ();
    srt_rsp_if rsp_ch ();

    segment_reassembly_tracker_core #(
        .SESSIONS        (SESSIONS),
        .BUF_BYTES       (BUF_BYTES),
        .BASIC_HDR_BYTES (BASIC_HDR_BYTES),
        .SEG_HDR_BYTES   (SEG_HDR_BYTES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // session table mirror
    logic [TMR_W-1:0]   timeout_ticks;
    logic               sess_live  [SESSIONS];
    logic [SEQ_W-1:0]   sess_seq   [SESSIONS];
    logic [BYTES_W-1:0] sess_bytes [SESSIONS];
    logic [TMR_W-1:0]   sess_timer [SESSIONS];

    t_result          pending_results[$];
    logic [SEQ_W-1:0] seq_pool [8];
    int               error_count = 0;
    int               stall_left  = 0;
    int               cycle_count = 0;
    bit               ready_calm  = 1'b0;
    bit               send_calm   = 1'b0;

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= 200) begin
            $display("ERROR %0t: %s", $time, what);
        end
    endtask

    function automatic logic [15:0] sat16(logic [16:0] v);
        return (v > 17'hFFFF) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic void drop_session(int slot);
        sess_live[slot]  = 1'b0;
        sess_bytes[slot] = '0;
        sess_timer[slot] = '0;
    endfunction

    function automatic t_result track_pdu(t_pdu p);
        t_result     r;
        int          slot;
        int          hdr;
        logic [16:0] pay;
        logic [16:0] span;
        logic [17:0] sum;
        logic [15:0] off;
        r = '0;
        if (p.req_type == REQ_TICK) begin
            r.status = ST_TICK;
            for (int i = 0; i < SESSIONS; i++) begin
                if (sess_live[i]) begin
                    if (sess_timer[i] <= 1) begin
                        drop_session(i);
                        r.mask[i] = 1'b1;
                    end else begin
                        sess_timer[i]--;
                    end
                end
            end
            return r;
        end
        r.seq = p.seq;
        hdr = (p.kind == KIND_COMPLETE || p.kind == KIND_FIRST) ? BASIC_HDR_BYTES
                                                                : SEG_HDR_BYTES;
        if (p.plen < hdr) begin
            r.status = ST_TOO_SHORT;
            return r;
        end
        pay = 17'(p.plen) - 17'(hdr);
        if (p.kind == KIND_COMPLETE) begin
            r.status = (pay != 0) ? ST_DELIVERED : ST_EMPTY;
            r.len    = pay[15:0];
            return r;
        end
        off  = (p.kind == KIND_FIRST) ? '0 : p.off;
        slot = -1;
        for (int i = 0; i < SESSIONS; i++) begin
            if (slot < 0 && sess_live[i] && sess_seq[i] == p.seq) slot = i;
        end
        if (slot < 0 && p.kind == KIND_FIRST) begin
            for (int i = 0; i < SESSIONS; i++) begin
                if (slot < 0 && !sess_live[i]) begin
                    slot          = i;
                    sess_live[i]  = 1'b1;
                    sess_seq[i]   = p.seq;
                    sess_bytes[i] = '0;
                    sess_timer[i] = timeout_ticks;
                end
            end
        end
        if (slot < 0) begin
            r.status = ST_NO_SESSION;
            return r;
        end
        r.idx = slot[1:0];
        span  = 17'(off) + pay;
        if (span > BUF_BYTES) begin
            drop_session(slot);
            r.status = ST_OVERFLOW;
            r.len    = sat16(span);
            return r;
        end
        sum = 18'(sess_bytes[slot]) + 18'(pay);
        sess_bytes[slot] = (sum > 18'(BYTES_MAX)) ? BYTES_MAX : sum[16:0];
        if (p.kind == KIND_LAST) begin
            r.len = span[15:0];
            if (sess_bytes[slot] == span) begin
                drop_session(slot);
                r.status = ST_REASSEMBLED;
            end else begin
                r.status = ST_MISMATCH;
            end
            return r;
        end
        sess_timer[slot] = timeout_ticks;
        r.status = ST_STORED;
        r.len    = sat16(sess_bytes[slot]);
        return r;
    endfunction

    function automatic t_pdu seg(logic [1:0] kind, int seq, int off, int plen);
        t_pdu p;
        p.req_type = REQ_PDU;
        p.kind     = kind;
        p.seq      = SEQ_W'(seq);
        p.off      = OFF_W'(off);
        p.plen     = LEN_W'(plen);
        return p;
    endfunction

    function automatic t_pdu tick_req();
        t_pdu p;
        p = t_pdu'(PDU_W'({$urandom, $urandom}));
        p.req_type = REQ_TICK;
        return p;
    endfunction

    function automatic int stall_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic int idle_gap();
        if (send_calm || $urandom_range(0, 99) < 55) return 0;
        return stall_len();
    endfunction

    function automatic t_pdu make_item();
        t_pdu p;
        int   r;
        int   n;
        int   k;
        int   slot;
        p = t_pdu'(PDU_W'({$urandom, $urandom}));
        p.req_type = REQ_PDU;
        p.seq = ($urandom_range(0, 3) != 0) ? seq_pool[$urandom_range(0, 7)] : SEQ_W'($urandom);
        r = $urandom_range(0, 99);
        if (r < 10) return tick_req();
        if (r < 16) begin
            p.kind = KIND_COMPLETE;
            if ($urandom_range(0, 3) != 0) p.plen = LEN_W'($urandom_range(0, 40));
            return p;
        end
        if (r >= 84) return p;
        n = 0;
        for (int i = 0; i < SESSIONS; i++) if (sess_live[i]) n++;
        if (r < 34 || n == 0) begin
            p.kind = KIND_FIRST;
            p.plen = LEN_W'(BASIC_HDR_BYTES + $urandom_range(0, 300));
            return p;
        end
        k    = $urandom_range(0, n - 1);
        slot = 0;
        for (int i = 0; i < SESSIONS; i++) begin
            if (sess_live[i]) begin
                if (k == 0) slot = i;
                k--;
            end
        end
        p.kind = (r < 64) ? KIND_MIDDLE : KIND_LAST;
        p.seq  = sess_seq[slot];
        p.off  = sess_bytes[slot][15:0];
        if ($urandom_range(0, 99) < 15) p.off = p.off + OFF_W'($urandom_range(1, 8));
        if ($urandom_range(0, 99) >= 5) begin
            p.plen = LEN_W'(SEG_HDR_BYTES + $urandom_range(0, 300));
        end
        return p;
    endfunction

    task automatic send_item(input t_pdu p);
        int gap;
        gap = idle_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.req_type    <= p.req_type;
        req_ch.seg_kind    <= p.kind;
        req_ch.seq_num     <= p.seq;
        req_ch.byte_offset <= p.off;
        req_ch.pdu_len     <= p.plen;
        req_ch.valid       <= 1'b1;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        pending_results.push_back(track_pdu(p));
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic verify_timeout_reg();
        logic [31:0] rd;
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        paddr   <= TIMEOUT_ADDR;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rd = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== {16'd0, timeout_ticks}) begin
            report_mismatch($sformatf("timeout register read %0d exp %0d", rd, timeout_ticks));
        end
    endtask

    task automatic set_timeout(input int value);
        wait_idle();
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= TIMEOUT_ADDR;
        pwdata  <= 32'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        timeout_ticks = TMR_W'(value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        verify_timeout_reg();
    endtask

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result, status %0d", rsp_ch.status));
            end else begin
                want = pending_results.pop_front();
                if (rsp_ch.status !== want.status)
                    report_mismatch($sformatf("status got %0d exp %0d (seq %0d)",
                                              rsp_ch.status, want.status, want.seq));
                if (rsp_ch.session_index !== want.idx)
                    report_mismatch($sformatf("session_index got %0d exp %0d (seq %0d)",
                                              rsp_ch.session_index, want.idx, want.seq));
                if (rsp_ch.deliver_len !== want.len)
                    report_mismatch($sformatf("deliver_len got %0d exp %0d (seq %0d)",
                                              rsp_ch.deliver_len, want.len, want.seq));
                if (rsp_ch.deliver_seq !== want.seq)
                    report_mismatch($sformatf("deliver_seq got %0d exp %0d",
                                              rsp_ch.deliver_seq, want.seq));
                if (rsp_ch.expired_mask !== want.mask)
                    report_mismatch($sformatf("expired_mask got %b exp %b",
                                              rsp_ch.expired_mask, want.mask));
            end
        end
    end

    always @(negedge i_clk) begin
        cycle_count++;
        if (cycle_count % 400 == 0) ready_calm = ($urandom_range(0, 3) == 0);
        if (stall_left == 0 && !ready_calm && $urandom_range(0, 99) < 25) begin
            stall_left = stall_len();
        end
        if (stall_left != 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    task automatic test_complete_sdu();
        send_item(seg(KIND_COMPLETE, 0, 0, 0));
        send_item(seg(KIND_COMPLETE, 1023, 0, 1));
        send_item(seg(KIND_COMPLETE, 5, 0, 2));
        send_item(seg(KIND_COMPLETE, 6, 0, 3));
        send_item(seg(KIND_COMPLETE, 1023, 65535, 4095));
    endtask

    task automatic test_bad_length();
        send_item(seg(KIND_MIDDLE, 7, 0, 3));
        send_item(seg(KIND_LAST, 7, 0, 0));
        send_item(seg(KIND_FIRST, 7, 0, 1));
        send_item(seg(KIND_MIDDLE, 9, 10, 50));
        send_item(seg(KIND_LAST, 9, 0, 4));
    endtask

    task automatic test_reassembly();
        send_item(seg(KIND_FIRST, 1023, 65535, 102));
        send_item(seg(KIND_FIRST, 1023, 0, 12));
        send_item(seg(KIND_MIDDLE, 1023, 110, 94));
        send_item(seg(KIND_LAST, 1023, 150, 10));
        send_item(seg(KIND_LAST, 1023, 206, 4));
        send_item(seg(KIND_FIRST, 0, 0, 2));
        send_item(seg(KIND_LAST, 0, 0, 4));
    endtask

    task automatic test_byte_saturation();
        send_item(seg(KIND_FIRST, 512, 0, 4093));
        repeat (33) send_item(seg(KIND_MIDDLE, 512, 0, 4095));
        send_item(seg(KIND_LAST, 512, 0, 4));
    endtask

    task automatic test_session_timeout();
        set_timeout(2);
        send_item(seg(KIND_FIRST, 300, 0, 10));
        send_item(tick_req());
        send_item(seg(KIND_MIDDLE, 300, 8, 4));
        send_item(tick_req());
        send_item(tick_req());
        set_timeout(1);
        send_item(seg(KIND_FIRST, 301, 0, 2));
        send_item(tick_req());
    endtask

    task automatic test_table_full();
        for (int n = 0; n < SESSIONS; n++) send_item(seg(KIND_FIRST, 100 + n, 0, 10));
        send_item(seg(KIND_FIRST, 200, 0, 10));
        send_item(seg(KIND_MIDDLE, sess_seq[2], 4000, 4095));
        send_item(seg(KIND_MIDDLE, sess_seq[1], 65535, 4095));
        send_item(seg(KIND_MIDDLE, sess_seq[0], 5, 4095));
        send_item(seg(KIND_FIRST, 200, 0, 10));
    endtask

    task automatic random_phase(input int timeout_value, input int count);
        set_timeout(timeout_value);
        foreach (seq_pool[i]) seq_pool[i] = SEQ_W'($urandom);
        for (int k = 0; k < count; k++) begin
            if (k % 100 == 0) send_calm = ($urandom_range(0, 3) == 0);
            send_item(make_item());
        end
        send_calm = 1'b0;
    endtask

    task automatic test_random_traffic();
        random_phase(40, 500);
        random_phase(3, 300);
        random_phase(1, 150);
        random_phase(65535, 350);
        random_phase(12, 400);
    endtask

    initial begin
        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        req_ch.valid       = 1'b0;
        req_ch.req_type    = REQ_PDU;
        req_ch.seg_kind    = KIND_COMPLETE;
        req_ch.seq_num     = '0;
        req_ch.byte_offset = '0;
        req_ch.pdu_len     = '0;
        rsp_ch.ready       = 1'b0;
        timeout_ticks      = TIMEOUT_RST;
        for (int i = 0; i < SESSIONS; i++) begin
            sess_live[i] = 1'b0;
            sess_seq[i]  = '0;
            drop_session(i);
        end
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        verify_timeout_reg();
        test_complete_sdu();
        test_bad_length();
        test_reassembly();
        test_byte_saturation();
        test_session_timeout();
        test_table_full();
        test_random_traffic();

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

@@ segment_reassembly_tracker_core.f @@
rtl/srt_pkg.sv
rtl/srt_if.sv
rtl/srt_find.sv
rtl/segment_reassembly_tracker_core.sv
rtl/srt_chk.sv
tb/tb_segment_reassembly_tracker_core.sv
